FILE: src/gcd_pkg.sv
// Package with widths, types and constants shared by the gate clock divider files.
`default_nettype none

package gcd_pkg;

  localparam int unsigned DIV_W       = 8;
  localparam int unsigned PW_W        = 16;
  localparam int unsigned CNT_W       = 24;
  localparam int unsigned Q_FRAC_BITS = 12;
  localparam int unsigned PROD_W      = CNT_W + PW_W;

  typedef logic [DIV_W-1:0]  div_t;
  typedef logic [PW_W-1:0]   pw_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [PROD_W-1:0] prod_t;

  localparam div_t EDGE_MAX = {DIV_W{1'b1}};
  localparam cnt_t CNT_MAX  = {CNT_W{1'b1}};

endpackage : gcd_pkg

`default_nettype wire

FILE: src/gcd_in_if.sv
// Interfaces for the input and result channels of the gate clock divider.
`default_nettype none

interface gcd_in_if import gcd_pkg::*; ();
  logic valid;
  logic ready;
  logic reset_high;
  logic clock_high;
  div_t divider;
  pw_t  pulse_width;

  modport source (output valid, output reset_high, output clock_high,
                  output divider, output pulse_width, input ready);
  modport sink   (input valid, input reset_high, input clock_high,
                  input divider, input pulse_width, output ready);
endinterface : gcd_in_if

interface gcd_out_if import gcd_pkg::*; ();
  logic valid;
  logic ready;
  logic gate_out;

  modport source (output valid, output gate_out, input ready);
  modport sink   (input valid, input gate_out, output ready);
endinterface : gcd_out_if

`default_nettype wire

FILE: src/gate_clock_divider_unit.sv
// Top level of the gate clock divider: edge counting, period capture and gate output.
//
// Usage:
//   in_chan carries one sample per transaction: the reset and clock levels,
//   the divider (rising clock edges per output pulse) and the pulse width as
//   an unsigned Q4.12 fraction of the measured period.
//   out_chan carries one transaction per input sample: the gate level after
//   that sample.
// Timing and throughput:
//   The whole update is done in the cycle the sample is accepted; the
//   result sits in the output register from the next cycle on. One
//   sample is accepted per cycle (in_chan.ready is high whenever the
//   output register is empty or is being drained). The single 24x16
//   multiply-and-compare of the pulse-width check sets the cycle time.
// Reset:
//   rst_n (synchronous, active low) clears all counters, the latched period,
//   the gate level and the output register. Reset also clears an edge count
//   that would otherwise start undefined.
// Stall:
//   When the receiver holds out_chan.ready low with a result pending,
//   in_chan.ready drops and the state holds until the result is taken.
`default_nettype none

module gate_clock_divider_unit import gcd_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  gcd_in_if.sink       in_chan,
  gcd_out_if.source    out_chan
);

  // Divider state.
  logic last_reset_r, last_clock_r, level_r;
  div_t edge_count_r;
  cnt_t sample_count_r, period_len_r, phase_count_r;

  // Output register.
  logic out_valid_r, out_gate_r;

  logic in_accept;

  // Next-state terms.
  logic  rst_rise, clk_rise, fire, pulse_end;
  div_t  edge_clr, edge_inc;
  cnt_t  sample_clr, sample_inc, phase_clr, phase_fire, phase_inc;
  cnt_t  period_len_nxt, sample_count_nxt, phase_count_nxt;
  div_t  edge_count_nxt;
  logic  level_fire, level_nxt;
  prod_t phase_scaled, threshold;

  assign in_chan.ready     = !out_valid_r || out_chan.ready;
  assign in_accept         = in_chan.valid && in_chan.ready;
  assign out_chan.valid    = out_valid_r;
  assign out_chan.gate_out = out_gate_r;

  always_comb begin
    // A rising reset clears edge, sample and phase counters.
    rst_rise   = in_chan.reset_high && !last_reset_r;
    edge_clr   = rst_rise ? '0 : edge_count_r;
    sample_clr = rst_rise ? '0 : sample_count_r;
    phase_clr  = rst_rise ? '0 : phase_count_r;

    // Count rising clock edges, saturating.
    clk_rise = in_chan.clock_high && !last_clock_r;
    edge_inc = (clk_rise && (edge_clr != EDGE_MAX)) ? edge_clr + div_t'(1) : edge_clr;

    sample_inc = (sample_clr != CNT_MAX) ? sample_clr + cnt_t'(1) : sample_clr;

    // Divider reached: latch the period and start a new pulse.
    fire             = (edge_inc >= in_chan.divider);
    period_len_nxt   = fire ? sample_inc : period_len_r;
    sample_count_nxt = fire ? '0 : sample_inc;
    phase_fire       = fire ? '0 : phase_clr;
    level_fire       = fire ? 1'b1 : level_r;
    edge_count_nxt   = fire ? '0 : edge_inc;

    phase_inc = (phase_fire != CNT_MAX) ? phase_fire + cnt_t'(1) : phase_fire;

    // Exact compare: phase * 1.0 against period * pulse width in Q4.12.
    phase_scaled = prod_t'({phase_inc, {Q_FRAC_BITS{1'b0}}});
    threshold    = prod_t'(period_len_nxt) * prod_t'(in_chan.pulse_width);
    pulse_end    = (phase_scaled > threshold);

    phase_count_nxt = pulse_end ? '0 : phase_inc;
    level_nxt       = pulse_end ? 1'b0 : level_fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_reset_r   <= 1'b0;
      last_clock_r   <= 1'b0;
      edge_count_r   <= '0;
      sample_count_r <= '0;
      period_len_r   <= '0;
      phase_count_r  <= '0;
      level_r        <= 1'b0;
      out_valid_r    <= 1'b0;
      out_gate_r     <= 1'b0;
    end else begin
      if (in_accept) begin
        // Advance the state and load the result for this transaction.
        last_reset_r   <= in_chan.reset_high;
        last_clock_r   <= in_chan.clock_high;
        edge_count_r   <= edge_count_nxt;
        sample_count_r <= sample_count_nxt;
        period_len_r   <= period_len_nxt;
        phase_count_r  <= phase_count_nxt;
        level_r        <= level_nxt;
        out_valid_r    <= 1'b1;
        out_gate_r     <= level_nxt;
      end else if (out_chan.ready) begin
        // Drop the result once taken.
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule : gate_clock_divider_unit

`default_nettype wire

FILE: tb/sv/gate_clock_divider_unit_tb.sv
// Testbench for the gate clock divider: directed table, then random samples checked by a predictor.
`timescale 1ns / 1ps

module gate_clock_divider_unit_tb;
  import gcd_pkg::*;

  localparam int CLK_HALF_NS   = 10;
  localparam int RESET_CYCLES  = 10;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_ITEMS   = 262;
  localparam int RX_HOLD_LEN   = 300;
  localparam int DRAIN_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int MAX_REPORTS   = 10;

  // One row of the directed table: the sample fields, plus an optional
  // hand-typed gate level for rows whose outcome is obvious.
  typedef struct packed {
    logic rst_lvl;
    logic clk_lvl;
    div_t div;
    pw_t  pw;
    logic has_gate;
    logic gate;
  } sample_row_t;

  // Divider state as the predictor keeps it.
  typedef struct packed {
    logic prev_rst;
    logic prev_clk;
    div_t edges;
    cnt_t samples;
    cnt_t period;
    cnt_t phase;
    logic lvl;
  } divider_state_t;

  logic clk = 1'b0;
  logic rst_n;

  gcd_in_if  in_if ();
  gcd_out_if out_if ();

  gate_clock_divider_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if.sink),
    .out_chan (out_if.source)
  );

  // Clock: 20 ns period, starts low so the first rising edge is clean.
  always begin
    #CLK_HALF_NS clk = 1'b1;
    #CLK_HALF_NS clk = 1'b0;
  end

  divider_state_t div_st = '0;
  logic           gate_q[$];      // gate levels still owed by the block
  int             mismatches = 0;
  int             cycle_cnt  = 0;
  int             tx_idle_pct = 0;
  int             rx_stall_pct = 0;
  logic           rx_hold_req = 1'b0;
  logic           rx_hold_done = 1'b0;
  int             rx_hold_cnt = 0;

  // Typed expectation travels with the payload, so the acceptance monitor
  // sees it at the same edge as the sample it belongs to.
  logic row_has_gate;
  logic row_gate;

  // Advance the divider state by one sample and return the new gate level.
  function logic predict_gate(input logic r, input logic c, input div_t d, input pw_t p);
    prod_t phase_scaled;
    prod_t period_scaled;
    // Only a rising reset clears; a held reset leaves the counters alone.
    if (!div_st.prev_rst && r) begin
      div_st.edges   = '0;
      div_st.samples = '0;
      div_st.phase   = '0;
    end
    div_st.prev_rst = r;
    if (!div_st.prev_clk && c)
      div_st.edges = (div_st.edges == EDGE_MAX) ? EDGE_MAX : div_st.edges + div_t'(1);
    div_st.prev_clk = c;
    div_st.samples = (div_st.samples == CNT_MAX) ? CNT_MAX : div_st.samples + cnt_t'(1);
    // Enough edges: latch the period and start a new pulse. A zero divider
    // fires on every sample.
    if (div_st.edges >= d) begin
      div_st.period  = div_st.samples;
      div_st.samples = '0;
      div_st.phase   = '0;
      div_st.lvl     = 1'b1;
      div_st.edges   = '0;
    end
    div_st.phase = (div_st.phase == CNT_MAX) ? CNT_MAX : div_st.phase + cnt_t'(1);
    // Exact compare: phase in Q.12 against period times the Q4.12 width.
    phase_scaled  = prod_t'(div_st.phase) << Q_FRAC_BITS;
    period_scaled = prod_t'(div_st.period) * prod_t'(p);
    if (phase_scaled > period_scaled) begin
      div_st.lvl   = 1'b0;
      div_st.phase = '0;
    end
    return div_st.lvl;
  endfunction

  // Scoreboard: pop and compare each result first, then record the
  // expectation for any sample accepted at the same edge.
  always @(posedge clk) begin
    logic want;
    logic pred;
    if (out_if.valid && out_if.ready) begin
      if (gate_q.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("[%0t] unexpected result: gate_out=%0b", $realtime, out_if.gate_out);
        mismatches++;
      end else begin
        want = gate_q.pop_front();
        if (out_if.gate_out !== want) begin
          if (mismatches < MAX_REPORTS)
            $display("[%0t] gate_out mismatch: expected %0b, actual %0b",
                     $realtime, want, out_if.gate_out);
          mismatches++;
        end
      end
    end
    if (rst_n && in_if.valid && in_if.ready) begin
      pred = predict_gate(in_if.reset_high, in_if.clock_high, in_if.divider,
                          in_if.pulse_width);
      gate_q.push_back(row_has_gate ? row_gate : pred);
    end
  end

  // Receiver: a one-off long hold when requested, otherwise random stalls
  // at the current rate. The hold is counted here, not in the main flow.
  always @(posedge clk) begin
    if (rx_hold_req && !rx_hold_done) begin
      out_if.ready <= 1'b0;
      rx_hold_cnt  <= rx_hold_cnt + 1;
      if (rx_hold_cnt == RX_HOLD_LEN - 1)
        rx_hold_done <= 1'b1;
    end else if (rx_stall_pct == 0) begin
      out_if.ready <= 1'b1;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Watchdog: end the run with a failure once the total cycle limit is reached.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one sample, idling first at the sender's current rate, and hold
  // it until the transaction completes.
  task automatic send_sample(input logic r, input logic c, input div_t d, input pw_t p,
                             input logic has_g, input logic g);
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.reset_high  <= r;
    in_if.clock_high  <= c;
    in_if.divider     <= d;
    in_if.pulse_width <= p;
    row_has_gate      <= has_g;
    row_gate          <= g;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Pause the sender until every owed result has been taken.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (gate_q.size() != 0) @(posedge clk);
  endtask

  // Random samples in bursts: mostly a clean square clock with a fixed
  // divider and a mostly fixed width, rare short reset pulses; some bursts are pure noise.
  task automatic run_random(input int n_items);
    int   sent;
    int   burst_len;
    int   half;
    int   half_left;
    int   rst_left;
    logic noisy;
    logic clk_lvl;
    logic rst_lvl;
    div_t d;
    pw_t  p;
    sent    = 0;
    clk_lvl = 1'b0;
    rst_lvl = 1'b0;
    while (sent < n_items) begin
      burst_len = $urandom_range(16, 64);
      noisy     = ($urandom_range(0, 7) == 0);
      case ($urandom_range(0, 9))
        0:       d = div_t'($urandom_range(0, 255));
        1:       d = EDGE_MAX;
        default: d = div_t'($urandom_range(0, 6));
      endcase
      if ($urandom_range(0, 3) == 0)
        p = pw_t'($urandom);
      else
        p = pw_t'($urandom_range(0, 16'h2000));
      half      = $urandom_range(1, 4);
      half_left = half;
      rst_left  = 0;
      repeat (burst_len) begin
        if (noisy) begin
          clk_lvl = 1'($urandom_range(0, 1));
          rst_lvl = 1'($urandom_range(0, 1));
        end else begin
          if (half_left == 0) begin
            clk_lvl   = ~clk_lvl;
            half_left = half;
          end
          half_left--;
          if (rst_left > 0)
            rst_left--;
          else if ($urandom_range(0, 47) == 0)
            rst_left = $urandom_range(1, 3);
          rst_lvl = (rst_left > 0);
        end
        // Occasionally jump the width mid-burst to hit the upper bits.
        if ($urandom_range(0, 31) == 0)
          p = pw_t'($urandom);
        send_sample(rst_lvl, clk_lvl, d, p, 1'b0, 1'b0);
        sent++;
      end
    end
  endtask

  // Directed table. Only the first rows carry a typed gate level: with the
  // state cleared, a zero divider fires at once with a one-sample period,
  // so the gate stays high only if the width is at least 1.0.
  sample_row_t directed_rows[] = '{
    '{1'b0, 1'b0, 8'd0,   16'h0000, 1'b1, 1'b0},
    '{1'b0, 1'b0, 8'd0,   16'hFFFF, 1'b1, 1'b1},
    // rising reset together with a rising clock
    '{1'b1, 1'b1, 8'd255, 16'hFFFF, 1'b0, 1'b0},
    // reset held high has no further effect
    '{1'b1, 1'b0, 8'd255, 16'hFFFF, 1'b0, 1'b0},
    '{1'b1, 1'b1, 8'd255, 16'hFFFF, 1'b0, 1'b0},
    // divide by two at a width of exactly 1.0
    '{1'b0, 1'b0, 8'd2,   16'h1000, 1'b0, 1'b0},
    '{1'b0, 1'b1, 8'd2,   16'h1000, 1'b0, 1'b0},
    '{1'b0, 1'b0, 8'd2,   16'h1000, 1'b0, 1'b0},
    '{1'b0, 1'b1, 8'd2,   16'h1000, 1'b0, 1'b0},
    '{1'b0, 1'b0, 8'd2,   16'h1000, 1'b0, 1'b0},
    '{1'b0, 1'b1, 8'd2,   16'h1000, 1'b0, 1'b0},
    '{1'b0, 1'b0, 8'd2,   16'h1000, 1'b0, 1'b0},
    '{1'b0, 1'b1, 8'd2,   16'h1000, 1'b0, 1'b0},
    // half width
    '{1'b0, 1'b0, 8'd2,   16'h0800, 1'b0, 1'b0},
    '{1'b0, 1'b0, 8'd2,   16'h0800, 1'b0, 1'b0},
    // divide by one, tiny and large widths
    '{1'b0, 1'b1, 8'd1,   16'h0001, 1'b0, 1'b0},
    '{1'b0, 1'b0, 8'd1,   16'h8000, 1'b0, 1'b0},
    '{1'b0, 1'b1, 8'd1,   16'h8000, 1'b0, 1'b0},
    '{1'b0, 1'b0, 8'd1,   16'h8000, 1'b0, 1'b0},
    '{1'b0, 1'b1, 8'd1,   16'hFFFF, 1'b0, 1'b0},
    // second rising reset, then zero divider and a wide divider
    '{1'b1, 1'b0, 8'd1,   16'h0000, 1'b0, 1'b0},
    '{1'b0, 1'b1, 8'd0,   16'h5555, 1'b0, 1'b0},
    '{1'b0, 1'b0, 8'd128, 16'hAAAA, 1'b0, 1'b0}
  };

  initial begin
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.reset_high   <= 1'b0;
    in_if.clock_high   <= 1'b0;
    in_if.divider      <= '0;
    in_if.pulse_width  <= '0;
    row_has_gate       <= 1'b0;
    row_gate           <= 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table with both sides always ready.
    foreach (directed_rows[i])
      send_sample(directed_rows[i].rst_lvl, directed_rows[i].clk_lvl, directed_rows[i].div,
                  directed_rows[i].pw, directed_rows[i].has_gate, directed_rows[i].gate);
    drain_results();

    // Random phases: no idling (with the long receiver hold up front so the
    // block backs up against a steady sender), sender idle, receiver stalls,
    // then both idling lightly.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct   = 0;
          rx_stall_pct <= 0;
          rx_hold_req  <= 1'b1;
        end
        1: begin
          tx_idle_pct   = 74;
          rx_stall_pct <= 0;
        end
        2: begin
          tx_idle_pct   = 0;
          rx_stall_pct <= 74;
        end
        default: begin
          tx_idle_pct   = 17;
          rx_stall_pct <= 17;
        end
      endcase
      run_random(PHASE_ITEMS);
      drain_results();
    end

    // Let any straggling result show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && gate_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
